// ===== sv/ffha_pkg.sv =====
// Shared types, codes and constants for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_WORDS_DEF = 1024;
  localparam int ADDR_W         = 12;
  localparam int SIZE_W         = 12;
  localparam int HDR_BYTES      = 4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [ADDR_W-1:0] block_addr;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_SPLIT,
    ST_FREE_WR
  } state_t;

endpackage

// ===== sv/ffha_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ffha_ctrl.sv =====
// Request sequencer: header walk, block placement, free and result register.
module ffha_ctrl #(
  parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
  localparam int AW  = $clog2(HEAP_WORDS),
  localparam int SZW = AW + 2,
  localparam int HW  = SZW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ffha_pkg::req_t   in_req,
  output logic             busy,
  output logic             out_valid,
  output ffha_pkg::rsp_t   out_rsp,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [HW-1:0]    ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  logic [HW-1:0]    ram_rdata
);

  localparam int PW  = AW + 1;
  localparam int RBW = (AW + 3 > 14) ? AW + 3 : 14;
  localparam logic [SZW-1:0] INIT_SIZE = SZW'((HEAP_WORDS - 1) * ffha_pkg::HDR_BYTES);
  localparam logic [RBW-1:0] HDR_B     = RBW'(ffha_pkg::HDR_BYTES);
  localparam logic [RBW-1:0] HEAP_LIM  = RBW'(HEAP_WORDS);

  ffha_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    rs_r, rs_nxt;
  logic [RBW-1:0]   rb_r, rb_nxt;
  logic [RBW-1:0]   need_r, need_nxt;
  logic [AW-1:0]    fw_r, fw_nxt;
  logic [AW-1:0]    rest_w_r, rest_w_nxt;
  logic [SZW-1:0]   rest_sz_r, rest_sz_nxt;
  logic             out_valid_r, out_valid_nxt;
  ffha_pkg::rsp_t   out_rsp_r, out_rsp_nxt;

  logic [SZW-1:0]   hsize;
  logic             halloc;
  logic [AW-1:0]    run_st;
  logic [RBW-1:0]   rb_sum;
  logic [PW-1:0]    ptr_step;
  logic [RBW-1:0]   rest_w_wide;
  logic [RBW-1:0]   blk_addr;
  logic [RBW-1:0]   req_need;
  logic [RBW-1:0]   free_w;

  assign hsize       = ram_rdata[HW-1:1];
  assign halloc      = ram_rdata[0];
  assign run_st      = (rb_r == '0) ? ptr_r[AW-1:0] : rs_r;
  assign rb_sum      = rb_r + RBW'(hsize) + HDR_B;
  assign ptr_step    = PW'(hsize[SZW-1:2]) + PW'(1);
  assign rest_w_wide = RBW'(run_st) + (need_r >> 2) + RBW'(1);
  assign blk_addr    = RBW'({run_st, 2'b00}) + HDR_B;
  assign req_need    = (RBW'(in_req.req_size) + RBW'(3)) & ~RBW'(3);
  assign free_w      = RBW'(in_req.free_addr[ffha_pkg::ADDR_W-1:2]) - RBW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::ST_INIT;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      rs_r        <= '0;
      rb_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      rs_r        <= rs_nxt;
      rb_r        <= rb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r    <= need_nxt;
    fw_r      <= fw_nxt;
    rest_w_r  <= rest_w_nxt;
    rest_sz_r <= rest_sz_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    rs_nxt        = rs_r;
    rb_nxt        = rb_r;
    need_nxt      = need_r;
    fw_nxt        = fw_r;
    rest_w_nxt    = rest_w_r;
    rest_sz_nxt   = rest_sz_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = ptr_r[AW-1:0];
    busy          = 1'b1;
    case (state_r)
      ffha_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {INIT_SIZE, 1'b0};
        state_nxt = ffha_pkg::ST_IDLE;
      end
      ffha_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_req.req_type == ffha_pkg::REQ_ALLOC) begin
            ram_raddr = '0;
            ptr_nxt   = '0;
            rs_nxt    = '0;
            rb_nxt    = '0;
            need_nxt  = req_need;
            state_nxt = ffha_pkg::ST_WALK;
          end else if (in_req.free_addr >= ffha_pkg::ADDR_W'(ffha_pkg::HDR_BYTES) &&
                       free_w < HEAP_LIM) begin
            ram_raddr = free_w[AW-1:0];
            fw_nxt    = free_w[AW-1:0];
            state_nxt = ffha_pkg::ST_FREE_WR;
          end else begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{success: 1'b1, block_addr: '0};
          end
        end
      end
      ffha_pkg::ST_WALK: begin
        if (RBW'(ptr_r) >= HEAP_LIM) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{success: 1'b0, block_addr: '0};
          state_nxt     = ffha_pkg::ST_IDLE;
        end else begin
          ptr_nxt   = ptr_r + ptr_step;
          ram_raddr = ptr_nxt[AW-1:0];
          rs_nxt    = run_st;
          if (halloc) begin
            rb_nxt = '0;
          end else if (rb_sum >= need_r + HDR_B) begin
            ram_we        = 1'b1;
            ram_waddr     = run_st;
            ram_wdata     = {need_r[SZW-1:0], 1'b1};
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{success: 1'b1,
                              block_addr: blk_addr[ffha_pkg::ADDR_W-1:0]};
            rest_w_nxt    = rest_w_wide[AW-1:0];
            rest_sz_nxt   = SZW'(rb_sum - need_r - (HDR_B << 1));
            if (rb_sum != need_r + HDR_B && rest_w_wide < HEAP_LIM) begin
              state_nxt = ffha_pkg::ST_SPLIT;
            end else begin
              state_nxt = ffha_pkg::ST_IDLE;
            end
          end else begin
            rb_nxt = rb_sum;
          end
        end
      end
      ffha_pkg::ST_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = rest_w_r;
        ram_wdata = {rest_sz_r, 1'b0};
        state_nxt = ffha_pkg::ST_IDLE;
      end
      ffha_pkg::ST_FREE_WR: begin
        ram_we        = 1'b1;
        ram_waddr     = fw_r;
        ram_wdata     = {hsize, 1'b0};
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{success: 1'b1, block_addr: '0};
        state_nxt     = ffha_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ffha_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator top level: header memory and request sequencer.
// Allocate: walks the headers first-fit from address 0, one header read per cycle from the
//   header RAM, and strobes the result when a block fits or the walk passes the heap end;
//   busy stays high through a split state that writes the leftover's header.
// Free: read-modify-write of one header before the strobe; an ignored free strobes in the cycle after accept.
// Reset: synchronous, active low; after reset an init state writes the whole-heap header.
module first_fit_heap_allocator #(
  parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ffha_pkg::req_t in_req,
  output logic           out_valid,
  output ffha_pkg::rsp_t out_rsp
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int HW = AW + 3;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [HW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [HW-1:0] ram_rdata;

  ffha_ram #(
    .WIDTH(HW),
    .DEPTH(HEAP_WORDS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ffha_ctrl #(
    .HEAP_WORDS(HEAP_WORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

endmodule

// ===== sv/ffha_checker.sv =====
// Port-level checks for the first-fit heap allocator, bound to the top level.
module ffha_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input ffha_pkg::req_t in_req,
  input logic           out_valid,
  input ffha_pkg::rsp_t out_rsp
);

  a_reset_init: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("reset does not hold off requests and results");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.success |-> out_rsp.block_addr == '0)
    else $error("failed allocate carries a nonzero address");

  a_addr_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.block_addr[1:0] == 2'b00)
    else $error("result address not word aligned");

  a_free_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.req_type == ffha_pkg::REQ_FREE |=> busy || out_valid)
    else $error("accepted free neither in progress nor answered");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_req   (in_req),
  .out_valid(out_valid),
  .out_rsp  (out_rsp)
);
